// File: hw/rtl/tbpt_pkg.sv
// Shared types, constants and helpers for the three-way bit-pair tally.
package tbpt_pkg;

    localparam int LANES      = 8;
    localparam int PHYS_LANES = 8;
    localparam int MAX_FIELDS = 65536;
    localparam int LANE_LIM   = (LANES < PHYS_LANES) ? LANES : PHYS_LANES;

    localparam int NPAT       = 8;
    localparam int TALLY_W    = 20;
    localparam int LANE_CNT_W = 4;
    localparam int SUM_W      = $clog2(LANE_LIM * 8 + 1);

    localparam longint TALLY_MAX_L =
        (longint'(8) * longint'(MAX_FIELDS) > longint'((1 << TALLY_W) - 1))
            ? longint'((1 << TALLY_W) - 1)
            : longint'(8) * longint'(MAX_FIELDS);
    localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(TALLY_MAX_L);

    typedef struct packed {
        logic [15:0] bits_i;
        logic [15:0] bits_j;
        logic [15:0] bits_k;
        logic [3:0]  lanes_used;
        logic        last_in;
    } t_in_item;

    typedef struct packed {
        logic [TALLY_W-1:0] count_000;
        logic [TALLY_W-1:0] count_001;
        logic [TALLY_W-1:0] count_010;
        logic [TALLY_W-1:0] count_011;
        logic [TALLY_W-1:0] count_100;
        logic [TALLY_W-1:0] count_101;
        logic [TALLY_W-1:0] count_110;
        logic [TALLY_W-1:0] count_111;
    } t_out_item;

    typedef logic [NPAT-1:0][LANE_CNT_W-1:0] t_lane_cnt;
    typedef logic [NPAT-1:0][SUM_W-1:0]      t_sum;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    // number of bits of v equal to b (0..2)
    function automatic logic [1:0] bits_eq(input logic [1:0] v, input logic b);
        logic [1:0] ones;
        ones = {1'b0, v[0]} + {1'b0, v[1]};
        return b ? ones : (2'd2 - ones);
    endfunction

endpackage

// File: hw/rtl/tbpt_lane.sv
// One lane: the eight pattern counts of a single field.
module tbpt_lane
    import tbpt_pkg::*;
(
    input  logic [1:0] i_a,
    input  logic [1:0] i_b,
    input  logic [1:0] i_c,
    input  logic       i_en,
    output t_lane_cnt  o_cnt
);

    always_comb begin
        logic [2:0]            pv;
        logic [LANE_CNT_W-1:0] ea;
        logic [LANE_CNT_W-1:0] eb;
        logic [LANE_CNT_W-1:0] ec;
        for (int p = 0; p < NPAT; p++) begin
            pv = 3'(p);
            ea = LANE_CNT_W'(bits_eq(i_a, pv[2]));
            eb = LANE_CNT_W'(bits_eq(i_b, pv[1]));
            ec = LANE_CNT_W'(bits_eq(i_c, pv[0]));
            // max 2*2*2 = 8, fits 4 bits
            o_cnt[p] = i_en ? (ea * eb * ec) : '0;
        end
    end

endmodule

// File: hw/rtl/tbpt_merge.sv
// Merge stage: sums the lane counts per pattern and registers them.
module tbpt_merge
    import tbpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  logic      i_last,
    input  t_lane_cnt i_cnt [LANE_LIM],
    output t_ctl      o_ctl,
    output t_sum      o_sum
);

    t_ctl r_ctl;
    t_sum r_sum;
    t_sum w_sum;

    always_comb begin
        logic [SUM_W-1:0] acc;
        for (int p = 0; p < NPAT; p++) begin
            acc = '0;
            for (int l = 0; l < LANE_LIM; l++) begin
                acc = acc + SUM_W'(i_cnt[l][p]);
            end
            w_sum[p] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl.valid <= i_valid;
            r_ctl.last  <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum <= w_sum;
        end
    end

    assign o_ctl = r_ctl;
    assign o_sum = r_sum;

endmodule

// File: hw/rtl/tbpt_accum.sv
// Running tallies with saturation and the result register.
module tbpt_accum
    import tbpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl      i_ctl,
    input  t_sum      i_sum,
    input  logic      i_out_stall,
    output logic      o_blocked,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic [NPAT-1:0][TALLY_W-1:0] r_tally;
    logic [NPAT-1:0][TALLY_W-1:0] w_sat;
    logic                         r_out_valid;
    t_out_item                    r_out;
    logic                         w_blocked;
    logic                         w_fire;

    // a last item waits only while the held result is not taken
    assign w_blocked = i_ctl.valid && i_ctl.last && r_out_valid && i_out_stall;
    assign w_fire    = i_ctl.valid && !w_blocked;

    always_comb begin
        logic [TALLY_W:0] s;
        for (int p = 0; p < NPAT; p++) begin
            s = {1'b0, r_tally[p]} + (TALLY_W + 1)'(i_sum[p]);
            w_sat[p] = (s > {1'b0, TALLY_MAX}) ? TALLY_MAX : s[TALLY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_tally <= i_ctl.last ? '0 : w_sat;
            end
            if (w_fire && i_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && i_ctl.last) begin
            r_out.count_000 <= w_sat[0];
            r_out.count_001 <= w_sat[1];
            r_out.count_010 <= w_sat[2];
            r_out.count_011 <= w_sat[3];
            r_out.count_100 <= w_sat[4];
            r_out.count_101 <= w_sat[5];
            r_out.count_110 <= w_sat[6];
            r_out.count_111 <= w_sat[7];
        end
    end

    assign o_blocked   = w_blocked;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_ctl.last |=> r_out_valid)
        else $error("last item did not produce a result");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_ctl.last |=> r_tally == '0)
        else $error("tallies not cleared after last item");

    a_tally_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> r_tally == $past(r_tally))
        else $error("tallies changed without an item");

    a_block_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_blocked |=> r_out_valid)
        else $error("held result lost while a last item waited");

endmodule

// File: hw/rtl/three_way_bit_pair_tally.sv
// Top level of the three-way bit-pair tally: lanes, merge and accumulator.
// Throughput: one item per cycle while the input is not stalled; all lanes of an item are counted in parallel.
// Path: an accepted item's lane counts and adder tree sum go into the merge
//   register; the tally add with saturation then puts a last item's result into
//   the result register at the output.
// Input stalls only while a last item meets a result still held at the output.
// Reset (i_rst_n low, synchronous): tallies cleared, pipeline and output empty.
module three_way_bit_pair_tally
    import tbpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_lane_cnt w_cnt [LANE_LIM];
    t_ctl      w_ctl;
    t_sum      w_sum;
    logic      w_blocked;
    logic      w_take;

    // an item enters the merge stage whenever the input is not stalled
    assign w_take     = i_in_valid && !w_blocked;
    assign o_in_stall = w_blocked;

    // one lane per field; lanes at or above lanes_used contribute nothing,
    // which also clamps oversized lane counts to the lanes present
    for (genvar g = 0; g < LANE_LIM; g++) begin : g_lane
        logic w_en;
        assign w_en = 32'(i_in_item.lanes_used) > g;

        tbpt_lane u_lane (
            .i_a   (i_in_item.bits_i[2*g +: 2]),
            .i_b   (i_in_item.bits_j[2*g +: 2]),
            .i_c   (i_in_item.bits_k[2*g +: 2]),
            .i_en  (w_en),
            .o_cnt (w_cnt[g])
        );
    end

    // merge stage advances unless its last item is held by a full output
    tbpt_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (!w_blocked),
        .i_valid (w_take),
        .i_last  (i_in_item.last_in),
        .i_cnt   (w_cnt),
        .o_ctl   (w_ctl),
        .o_sum   (w_sum)
    );

    tbpt_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_sum       (w_sum),
        .i_out_stall (i_out_stall),
        .o_blocked   (w_blocked),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
